FILE: design/mvss_pkg.sv
// Package for the motion-vector subblock splitter: widths, field types and
// the per-subblock median pick. No dependencies.
package mvss_pkg;

    localparam int MaxBlkX   = 256;
    localparam int MaxBlkY   = 256;
    localparam int ColW      = $clog2(MaxBlkX);
    localparam int RowW      = $clog2(MaxBlkY);
    localparam int DimW      = 9;
    localparam int WordW     = 64;
    localparam int VecW      = 32;
    localparam int SadOutW   = 30;
    localparam int IdxW      = 18;
    localparam int OutDataW  = 80;
    localparam int CfgIdxW   = 2;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_BLOCKS_X      = 2'd0,
        CFG_BLOCKS_Y      = 2'd1,
        CFG_MEDIAN_ENABLE = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_idx;

    // Median of three signed components
    function automatic logic signed [15:0] med3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
        logic signed [15:0] m;
        if ((b <= a && a <= c) || (c <= a && a <= b)) begin
            m = a;
        end else if ((a <= b && b <= c) || (c <= b && b <= a)) begin
            m = b;
        end else begin
            m = c;
        end
        return m;
    endfunction

    // Pick the subblock vector {y, x} from center, horizontal and vertical
    // neighbors; fall back to the center when the median pair is none of them.
    function automatic logic [VecW-1:0] pick(input logic [VecW-1:0] c,
                                             input logic [VecW-1:0] h,
                                             input logic [VecW-1:0] v);
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic [VecW-1:0]    m;
        mx = med3(c[15:0], h[15:0], v[15:0]);
        my = med3(c[31:16], h[31:16], v[31:16]);
        m  = {my, mx};
        if (m == c || m == h || m == v) begin
            return m;
        end
        return c;
    endfunction

endpackage

FILE: design/mvss_ram.sv
// One row bank of the vector line store: one write port, two registered
// read ports. Default widths come from mvss_pkg.
module mvss_ram #(
    parameter int Depth = mvss_pkg::MaxBlkX,
    parameter int Width = mvss_pkg::WordW,
    localparam int AddrW = $clog2(Depth)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AddrW-1:0] i_wr_addr,
    input  logic [Width-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AddrW-1:0] i_rd_addr0,
    input  logic [AddrW-1:0] i_rd_addr1,
    output logic [Width-1:0] o_rd_data0,
    output logic [Width-1:0] o_rd_data1
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] r_rd_data0;
    logic [Width-1:0] r_rd_data1;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read ports, data held between requests
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data0 <= mem[i_rd_addr0];
            r_rd_data1 <= mem[i_rd_addr1];
        end
    end

    assign o_rd_data0 = r_rd_data0;
    assign o_rd_data1 = r_rd_data1;

endmodule

FILE: design/motion_vector_subblock_split.sv
// Splits a raster block motion-vector field into half-size subblocks; uses
// mvss_pkg and three mvss_ram row banks.
//
// Each accepted request is written to a three-row line store, and the block
// one row above it leaves as four subblocks (top-left, top-right, bottom-left,
// bottom-right), one per cycle from the single output register unless the
// output stalls; on the last row the arriving block follows as four more. A
// request on the first row gives no results. The next request is taken in the
// cycle the final subblock of the current one is loaded. The line store reads
// the block above, its right neighbor and the block two rows up in the accept
// cycle; the left neighbor is kept from the previous request.
// Write configuration only while idle; a valid write to any index but the
// unused one restarts the field.
module motion_vector_subblock_split (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mvss_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [mvss_pkg::DimW-1:0]          i_cfg_data,
    // Input stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [15:0] vec_x, [31:16] vec_y, [63:32] vec_sad
    input  logic [mvss_pkg::WordW-1:0]         i_s_axis_tdata,
    // Output stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [15:0] out_x, [31:16] out_y, [61:32] out_sad, [79:62] out_index
    output logic [mvss_pkg::OutDataW-1:0]      o_m_axis_tdata,
    output logic                               o_m_axis_tlast
);

    localparam int ColW  = mvss_pkg::ColW;
    localparam int RowW  = mvss_pkg::RowW;
    localparam int DimW  = mvss_pkg::DimW;
    localparam int WordW = mvss_pkg::WordW;
    localparam int VecW  = mvss_pkg::VecW;
    localparam int IdxW  = mvss_pkg::IdxW;
    localparam int WW    = DimW + 1;

    // Configuration registers
    logic [DimW-1:0] r_blocks_x;
    logic [DimW-1:0] r_blocks_y;
    logic            r_median_en;
    logic            cfg_acc;

    // Field position and row bank rotation
    logic [ColW-1:0] r_col;
    logic [RowW-1:0] r_row;
    logic [1:0]      r_bank;

    // Item stage
    logic             r_a_valid;
    logic [WordW-1:0] r_a_vec;
    logic [1:0]       r_a_bank;
    logic             r_a_emit;
    logic             r_a_two;
    logic             r_a_inter;
    logic [IdxW-1:0]  r_a_base;
    logic [WW-1:0]    r_a_w;
    logic [2:0]       r_k;
    logic [VecW-1:0]  r_lft;

    // Output register
    logic                          r_o_valid;
    logic [mvss_pkg::OutDataW-1:0] r_o_data;
    logic                          r_o_last;

    logic [DimW-1:0]  nx;
    logic [DimW-1:0]  ny;
    logic             in_acc;
    logic             out_load;
    logic             a_done;
    logic             a_free;
    logic [2:0]       k_last;
    logic             row_end;
    logic             frame_end;

    logic [2:0]       bank_we;
    logic [WordW-1:0] rd0 [3];
    logic [WordW-1:0] rd1 [3];
    logic [WordW-1:0] rd_c;
    logic [WordW-1:0] rd_r;
    logic [WordW-1:0] rd_t;
    logic [1:0]       a_prev;
    logic [1:0]       a_prev2;

    logic [DimW-1:0]   col_ext;
    logic [DimW-1:0]   row_ext;
    logic [RowW-1:0]   row_m1;
    logic [RowW+DimW-1:0] row_prod;
    logic [IdxW-1:0]   n_base;
    logic              n_inter;

    logic [1:0]        sub;
    logic              blk1;
    logic [VecW-1:0]   cen;
    logic [VecW-1:0]   hor;
    logic [VecW-1:0]   ver;
    logic [VecW-1:0]   mv;
    logic [29:0]       sad;
    logic [IdxW-1:0]   idx;

    // Effective grid size with out-of-range values clamped
    always_comb begin
        if (r_blocks_x == '0) begin
            nx = DimW'(1);
        end else if (r_blocks_x > DimW'(mvss_pkg::MaxBlkX)) begin
            nx = DimW'(mvss_pkg::MaxBlkX);
        end else begin
            nx = r_blocks_x;
        end
        if (r_blocks_y < DimW'(2)) begin
            ny = DimW'(2);
        end else if (r_blocks_y > DimW'(mvss_pkg::MaxBlkY)) begin
            ny = DimW'(mvss_pkg::MaxBlkY);
        end else begin
            ny = r_blocks_y;
        end
    end

    // Handshake control
    assign cfg_acc     = i_cfg_valid;
    assign o_cfg_ready = 1'b1;
    assign k_last      = r_a_two ? 3'd7 : 3'd3;
    assign out_load    = r_a_valid && r_a_emit && (!r_o_valid || i_m_axis_tready);
    assign a_done      = r_a_valid && (!r_a_emit || (out_load && r_k == k_last));
    assign a_free      = !r_a_valid || a_done;
    assign in_acc      = i_s_axis_tvalid && a_free;
    assign o_s_axis_tready = a_free;

    // Position of the arriving block
    assign col_ext   = {1'b0, r_col};
    assign row_ext   = {1'b0, r_row};
    assign row_end   = (col_ext + DimW'(1)) >= nx;
    assign frame_end = (row_ext + DimW'(1)) >= ny;

    // Configuration registers, loaded on a valid write to a used index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_x  <= DimW'(1);
            r_blocks_y  <= DimW'(2);
            r_median_en <= 1'b0;
        end else if (cfg_acc) begin
            unique case (mvss_pkg::t_cfg_idx'(i_cfg_index))
                mvss_pkg::CFG_BLOCKS_X:      r_blocks_x  <= i_cfg_data;
                mvss_pkg::CFG_BLOCKS_Y:      r_blocks_y  <= i_cfg_data;
                mvss_pkg::CFG_MEDIAN_ENABLE: r_median_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Advance column, row and row bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_bank <= '0;
        end else if (cfg_acc && i_cfg_index != mvss_pkg::CFG_UNUSED) begin
            r_col  <= '0;
            r_row  <= '0;
            r_bank <= '0;
        end else if (in_acc) begin
            if (row_end) begin
                r_col <= '0;
                if (frame_end) begin
                    r_row  <= '0;
                    r_bank <= '0;
                end else begin
                    r_row  <= r_row + RowW'(1);
                    r_bank <= (r_bank == 2'd2) ? 2'd0 : r_bank + 2'd1;
                end
            end else begin
                r_col <= r_col + ColW'(1);
            end
        end
    end

    // Row bank line store: port 0 reads this column, port 1 the next one
    for (genvar g = 0; g < 3; g++) begin : g_bank
        assign bank_we[g] = in_acc && (r_bank == 2'(g));
        mvss_ram #(
            .Depth (mvss_pkg::MaxBlkX),
            .Width (WordW)
        ) u_ram (
            .i_clk      (i_clk),
            .i_wr_en    (bank_we[g]),
            .i_wr_addr  (r_col),
            .i_wr_data  (i_s_axis_tdata),
            .i_rd_en    (in_acc),
            .i_rd_addr0 (r_col),
            .i_rd_addr1 (r_col + ColW'(1)),
            .o_rd_data0 (rd0[g]),
            .o_rd_data1 (rd1[g])
        );
    end

    // Select row above and two rows above from the stored bank number
    always_comb begin
        a_prev  = (r_a_bank == 2'd0) ? 2'd2 : r_a_bank - 2'd1;
        a_prev2 = (r_a_bank == 2'd2) ? 2'd0 : r_a_bank + 2'd1;
        rd_c    = rd0[a_prev];
        rd_r    = rd1[a_prev];
        rd_t    = rd0[a_prev2];
    end

    // Output base index of the block above and median qualification
    always_comb begin
        row_m1   = r_row - RowW'(1);
        row_prod = row_m1 * nx;
        n_base   = IdxW'({row_prod, 2'b00}) + IdxW'({col_ext, 1'b0});
        n_inter  = r_median_en && (r_row >= RowW'(2)) && (r_col != '0) && !row_end;
    end

    // Item stage: load request, step through subblocks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_k       <= '0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
            r_k       <= '0;
        end else if (a_done) begin
            r_a_valid <= 1'b0;
        end else if (out_load) begin
            r_k <= r_k + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_vec   <= i_s_axis_tdata;
            r_a_bank  <= r_bank;
            r_a_emit  <= (r_row != '0);
            r_a_two   <= (r_row != '0) && frame_end;
            r_a_inter <= n_inter;
            r_a_base  <= n_base;
            r_a_w     <= {1'b0, nx} << 1;
            // center of the previous request is the left neighbor of this one
            r_lft     <= rd_c[VecW-1:0];
        end
    end

    // Build the current subblock
    always_comb begin
        sub  = r_k[1:0];
        blk1 = r_k[2];
        cen  = blk1 ? r_a_vec[VecW-1:0] : rd_c[VecW-1:0];
        sad  = blk1 ? r_a_vec[WordW-1:34] : rd_c[WordW-1:34];
        hor  = sub[0] ? rd_r[VecW-1:0] : r_lft;
        ver  = sub[1] ? r_a_vec[VecW-1:0] : rd_t[VecW-1:0];
        mv   = (!blk1 && r_a_inter) ? mvss_pkg::pick(cen, hor, ver) : cen;
        idx  = r_a_base
             + (blk1   ? IdxW'({r_a_w, 1'b0}) : IdxW'(0))
             + (sub[1] ? IdxW'(r_a_w) : IdxW'(0))
             + IdxW'(sub[0]);
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_data <= {idx, sad, mv};
            r_o_last <= (r_k == k_last);
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tlast  = r_o_last;

endmodule

FILE: sim/testbench.sv
// Self-checking bench for motion_vector_subblock_split: drives block vectors,
// predicts every subblock request and compares it field by field.
// Depends on mvss_pkg and the design sources only.
`timescale 1ns / 100ps

module testbench;

    localparam int MaxBlkX  = mvss_pkg::MaxBlkX;
    localparam int MaxBlkY  = mvss_pkg::MaxBlkY;
    localparam int DimW     = mvss_pkg::DimW;
    localparam int WordW    = mvss_pkg::WordW;
    localparam int SadOutW  = mvss_pkg::SadOutW;
    localparam int IdxW     = mvss_pkg::IdxW;
    localparam int OutDataW = mvss_pkg::OutDataW;

    localparam int RandItems     = 440;
    localparam int DrainCycles   = 24;
    localparam int HoldCycles    = 300;
    localparam int WatchdogLimit = 2000;
    localparam int PrintLimit    = 30;

    typedef struct {
        logic [15:0]        x;
        logic [15:0]        y;
        logic [SadOutW-1:0] sad;
        logic [IdxW-1:0]    idx;
        logic               last;
    } t_subblock;

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                cfg_valid     = 1'b0;
    mvss_pkg::t_cfg_idx  cfg_index     = mvss_pkg::CFG_BLOCKS_X;
    logic [DimW-1:0]     cfg_data      = '0;
    logic                cfg_ready;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // [15:0] vec_x, [31:16] vec_y, [63:32] vec_sad
    logic [WordW-1:0]    s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [15:0] out_x, [31:16] out_y, [61:32] out_sad, [79:62] out_index
    logic [OutDataW-1:0] m_axis_tdata;
    logic                m_axis_tlast;

    // Block vectors waiting to be offered, subblocks waiting to arrive
    logic [WordW-1:0]    vector_q[$];
    t_subblock           subblock_q[$];

    // Predicted block state and register copy
    logic [WordW-1:0]    row_mem [3*MaxBlkX];
    logic [DimW-1:0]     cfg_width  = 9'd1;
    logic [DimW-1:0]     cfg_height = 9'd2;
    logic                cfg_median = 1'b0;
    int unsigned         col_pos    = 0;
    int unsigned         row_pos    = 0;

    int                  mismatch_cnt = 0;
    int                  results_seen = 0;
    int                  stall_cycles = 0;
    bit                  s_taken      = 1'b0;
    bit                  tx_free      = 1'b0;
    bit                  rx_free      = 1'b0;
    bit                  rx_hold_req  = 1'b0;
    int                  gap_left     = 0;
    int                  burst_left   = 0;
    int                  rx_hold_left = 0;
    int                  rx_run_left  = 0;
    bit                  rx_run_ready = 1'b0;

    motion_vector_subblock_split u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_dim(input logic [DimW-1:0] v,
                                              input int unsigned lo,
                                              input int unsigned hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic logic signed [15:0] median3(input logic signed [15:0] a,
                                                   input logic signed [15:0] b,
                                                   input logic signed [15:0] c);
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) begin
            return lo;
        end
        if (c >= hi) begin
            return hi;
        end
        return c;
    endfunction

    // Median of center, horizontal and vertical vectors; keep the center when
    // the median pair is not one of the three. Vectors are {y, x}.
    function automatic logic [31:0] pick_subvector(input logic [31:0] c,
                                                   input logic [31:0] h,
                                                   input logic [31:0] v);
        logic signed [15:0] mx;
        logic signed [15:0] my;
        mx = median3(c[15:0], h[15:0], v[15:0]);
        my = median3(c[31:16], h[31:16], v[31:16]);
        if ((mx == c[15:0] && my == c[31:16]) || (mx == h[15:0] && my == h[31:16]) ||
            (mx == v[15:0] && my == v[31:16])) begin
            return {my, mx};
        end
        return c;
    endfunction

    function automatic logic [WordW-1:0] stored(input int unsigned row, input int unsigned col);
        return row_mem[(row % 3) * MaxBlkX + col];
    endfunction

    // Expect the four subblocks of block (bx, by)
    task automatic queue_block(input int unsigned bx, input int unsigned by,
                               input int unsigned nx, input int unsigned ny,
                               input bit closes_request);
        logic [WordW-1:0] ctr;
        logic [31:0]      lft;
        logic [31:0]      rgt;
        logic [31:0]      abv;
        logic [31:0]      blw;
        logic [31:0]      vec [4];
        int unsigned      w;
        int unsigned      base;
        int               k;
        t_subblock        sb;
        ctr = stored(by, bx);
        for (k = 0; k < 4; k++) begin
            vec[k] = ctr[31:0];
        end
        if (cfg_median && by > 0 && by + 1 < ny && bx > 0 && bx + 1 < nx) begin
            lft = 32'(stored(by, bx - 1));
            rgt = 32'(stored(by, bx + 1));
            abv = 32'(stored(by - 1, bx));
            blw = 32'(stored(by + 1, bx));
            vec[0] = pick_subvector(ctr[31:0], lft, abv);
            vec[1] = pick_subvector(ctr[31:0], rgt, abv);
            vec[2] = pick_subvector(ctr[31:0], lft, blw);
            vec[3] = pick_subvector(ctr[31:0], rgt, blw);
        end
        w    = 2 * nx;
        base = 2 * by * w + 2 * bx;
        for (k = 0; k < 4; k++) begin
            sb.x    = vec[k][15:0];
            sb.y    = vec[k][31:16];
            sb.sad  = ctr[63:34];
            sb.idx  = IdxW'(base + ((k >= 2) ? w : 0) + (k % 2));
            sb.last = closes_request && (k == 3);
            subblock_q.push_back(sb);
        end
    endtask

    // Store an accepted block vector and expect the subblocks it releases
    task automatic split_vector(input logic [WordW-1:0] word);
        int unsigned nx;
        int unsigned ny;
        int unsigned bx;
        int unsigned by;
        nx = clamp_dim(cfg_width, 1, MaxBlkX);
        ny = clamp_dim(cfg_height, 2, MaxBlkY);
        bx = (col_pos >= nx) ? nx - 1 : col_pos;
        by = (row_pos >= ny) ? ny - 1 : row_pos;
        row_mem[(by % 3) * MaxBlkX + bx] = word;
        if (by > 0) begin
            queue_block(bx, by - 1, nx, ny, by + 1 != ny);
            if (by + 1 == ny) begin
                queue_block(bx, by, nx, ny, 1'b1);
            end
        end
        if (bx + 1 >= nx) begin
            col_pos = 0;
            row_pos = (by + 1 >= ny) ? 0 : by + 1;
        end else begin
            col_pos = bx + 1;
            row_pos = by;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_cnt++;
        if (mismatch_cnt <= PrintLimit) begin
            $display("[%0t] result %0d: %s is %0h, expected %0h", $realtime, results_seen,
                     what, got, want);
        end
    endtask

    // Accept input requests and predict their results
    always @(posedge clk) begin : take_input
        s_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (s_taken) begin
            split_vector(s_axis_tdata);
        end
    end

    // Drive the input stream: hold a request until taken, then pull the next
    always @(negedge clk) begin : drive_input
        logic             next_valid;
        logic [WordW-1:0] next_data;
        next_valid = s_axis_tvalid;
        next_data  = s_axis_tdata;
        if (!s_axis_tvalid || s_taken) begin
            next_valid = 1'b0;
            if (gap_left > 0 && !tx_free) begin
                gap_left--;
            end else if (vector_q.size() > 0) begin
                next_data  = vector_q.pop_front();
                next_valid = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20)
                                                             : $urandom_range(0, 3);
                end
            end
        end
        s_axis_tvalid <= next_valid;
        s_axis_tdata  <= next_data;
    end

    // Drive output ready: alternate ready and stall runs, or hold off on request
    always @(negedge clk) begin : drive_ready
        logic next_ready;
        if (rx_hold_req) begin
            rx_hold_left = HoldCycles;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            next_ready = 1'b0;
        end else if (rx_free) begin
            next_ready = 1'b1;
        end else begin
            if (rx_run_left == 0) begin
                rx_run_ready = !rx_run_ready;
                rx_run_left  = rx_run_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
            end
            rx_run_left--;
            next_ready = rx_run_ready;
        end
        m_axis_tready <= next_ready;
    end

    // Compare each output request with the oldest expected subblock
    always @(posedge clk) begin : check_output
        t_subblock want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (subblock_q.size() == 0) begin
                report_mismatch("unexpected subblock, index", 32'(m_axis_tdata[79:62]), '0);
            end else begin
                want = subblock_q.pop_front();
                if (m_axis_tdata[15:0] !== want.x) begin
                    report_mismatch("out_x", 32'(m_axis_tdata[15:0]), 32'(want.x));
                end
                if (m_axis_tdata[31:16] !== want.y) begin
                    report_mismatch("out_y", 32'(m_axis_tdata[31:16]), 32'(want.y));
                end
                if (m_axis_tdata[61:32] !== want.sad) begin
                    report_mismatch("out_sad", 32'(m_axis_tdata[61:32]), 32'(want.sad));
                end
                if (m_axis_tdata[79:62] !== want.idx) begin
                    report_mismatch("out_index", 32'(m_axis_tdata[79:62]), 32'(want.idx));
                end
                if (m_axis_tlast !== want.last) begin
                    report_mismatch("tlast", 32'(m_axis_tlast), 32'(want.last));
                end
            end
            results_seen++;
        end
    end

    // End the run when no channel has moved for too long
    always @(posedge clk) begin : watchdog
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WatchdogLimit) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(input mvss_pkg::t_cfg_idx idx, input logic [DimW-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        if (idx == mvss_pkg::CFG_BLOCKS_X) begin
            cfg_width = val;
        end else if (idx == mvss_pkg::CFG_BLOCKS_Y) begin
            cfg_height = val;
        end else if (idx == mvss_pkg::CFG_MEDIAN_ENABLE) begin
            cfg_median = val[0];
        end
        // Any known register restarts the field
        if (idx != mvss_pkg::CFG_UNUSED) begin
            col_pos = 0;
            row_pos = 0;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every request is taken and every subblock has arrived
    task automatic settle();
        while (vector_q.size() != 0 || s_axis_tvalid || subblock_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic push_vec(input logic [15:0] x, input logic [15:0] y, input logic [31:0] sad);
        vector_q.push_back({sad, y, x});
    endtask

    function automatic logic [15:0] rand_comp();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            return 16'($urandom_range(0, 8)) - 16'd4;
        end
        if (sel < 9) begin
            return 16'($urandom);
        end
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return 16'h0000;
        endcase
    endfunction

    task automatic push_random(input int unsigned count);
        int unsigned n;
        logic [31:0] sad;
        for (n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0: sad = 32'h0;
                1: sad = 32'hFFFF_FFFF;
                default: sad = $urandom;
            endcase
            push_vec(rand_comp(), rand_comp(), sad);
        end
    endtask

    initial begin : stimulus
        int unsigned      phase;
        int unsigned      rand_items;
        int unsigned      area;
        int unsigned      count;
        int unsigned      first_part;
        logic [DimW-1:0]  wid;
        logic [DimW-1:0]  hgt;
        foreach (row_mem[i]) begin
            row_mem[i] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset geometry 1x2: every second request closes a frame with 8 subblocks
        push_vec(16'h7FFF, 16'h8000, 32'hFFFF_FFFF);
        push_vec(16'h8000, 16'h7FFF, 32'h0000_0000);
        push_vec(16'hFFFF, 16'h0000, 32'h0000_0003);
        push_vec(16'h0001, 16'hFFFF, 32'h8000_0000);
        settle();

        // 3x3 with median: center block gets fallbacks and a neighbor pick
        write_reg(mvss_pkg::CFG_BLOCKS_X, 9'd3);
        write_reg(mvss_pkg::CFG_BLOCKS_Y, 9'd3);
        write_reg(mvss_pkg::CFG_MEDIAN_ENABLE, 9'h1FF);
        push_vec(16'd0,     16'd0,     32'h0000_0007);
        push_vec(16'd5,     16'd10,    32'hFFFF_FFFF);
        push_vec(16'h7FFF,  16'h8000,  32'h0000_0001);
        push_vec(16'd10,    16'd5,     32'h0000_0003);
        push_vec(16'd0,     16'd0,     32'h1234_5678);
        push_vec(16'd1,     16'd1,     32'h0000_0000);
        push_vec(16'hFFFF,  16'hFFFF,  32'h8000_0000);
        push_vec(16'h8000,  16'h7FFF,  32'h0000_0004);
        push_vec(16'd0,     16'd0,     32'hFFFF_FFFC);
        settle();

        // Width 0 acts as 1, height 1 acts as 2; the unused index changes nothing
        write_reg(mvss_pkg::CFG_BLOCKS_X, 9'd0);
        write_reg(mvss_pkg::CFG_BLOCKS_Y, 9'd1);
        write_reg(mvss_pkg::CFG_UNUSED, 9'h1FF);
        push_vec(16'h1234, 16'hFEDC, 32'hDEAD_BEEF);
        push_vec(16'h0000, 16'h0000, 32'h0000_0002);
        settle();

        // Random phases of assorted geometry
        phase      = 0;
        rand_items = 0;
        while (rand_items < RandItems) begin
            if (phase == 1) begin
                wid = 9'd511;
                hgt = 9'd2;
            end else if (phase == 2) begin
                wid = 9'd2;
                hgt = 9'd511;
            end else if (phase == 3) begin
                wid = 9'($urandom_range(4, 8));
                hgt = 9'($urandom_range(3, 6));
            end else begin
                wid = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 1))
                                                  : 9'($urandom_range(2, 8));
                hgt = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 1))
                                                  : 9'($urandom_range(2, 6));
            end
            settle();
            write_reg(mvss_pkg::CFG_BLOCKS_X, wid);
            write_reg(mvss_pkg::CFG_BLOCKS_Y, hgt);
            write_reg(mvss_pkg::CFG_MEDIAN_ENABLE,
                      {8'($urandom), 1'($urandom_range(0, 3) != 0)});
            tx_free = ($urandom_range(0, 4) == 0);
            rx_free = ($urandom_range(0, 4) == 0);
            area = clamp_dim(wid, 1, MaxBlkX) * clamp_dim(hgt, 2, MaxBlkY);
            if (phase == 1) begin
                count = area / 2 + 3;
            end else if (phase == 2) begin
                count = 20;
            end else begin
                count = area * $urandom_range(1, 2) + $urandom_range(0, area - 1);
            end
            if (phase == 3) begin
                // Stall the output long enough for the block to back up its input
                push_random(count);
                rx_hold_req = 1'b1;
            end else if (phase == 4 || $urandom_range(0, 2) == 0) begin
                // Pause mid-frame until drained, then resume the same frame
                first_part = $urandom_range(1, count);
                push_random(first_part);
                settle();
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(mvss_pkg::CFG_UNUSED, 9'($urandom));
                end
                push_random(count - first_part);
            end else begin
                push_random(count);
            end
            rand_items += count;
            phase++;
        end
        settle();

        if (mismatch_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
